@@ design/krt_pkg.sv @@
package krt_pkg;

  // request codes
  typedef enum logic [3:0] {
    OP_REGISTER   = 4'd0,
    OP_DISCONNECT = 4'd1,
    OP_CREATE     = 4'd2,
    OP_READ       = 4'd3,
    OP_ALTER      = 4'd4,
    OP_RESERVE    = 4'd5,
    OP_RELEASE    = 4'd6,
    OP_LIST       = 4'd7,
    OP_STATS      = 4'd8
  } op_e;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP_ID  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EXISTS  = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_BUSY    = 3'd5;
  localparam logic [2:0] ST_UNHELD  = 3'd6;
  localparam logic [2:0] ST_FOREIGN = 3'd7;

  // list filter codes, anything else lists all
  localparam logic [1:0] FILT_FREE     = 2'd1;
  localparam logic [1:0] FILT_RESERVED = 2'd2;

  // key compare results for the slot under the scan pointers
  typedef struct packed {
    logic name_hit;
    logic owner_hit;
    logic client_hit;
  } hit_t;

endpackage

@@ design/keyed_reservation_table_unit.sv @@
// channel | handshake                 | payload
// request | in_valid_i / in_stall_o   | opcode_i entry_name_i client_key_i new_value_i
//         |                           | list_filter_i max_items_i
// result  | out_valid_o / out_stall_i | status_o item_*_o *_total_o last_o
//
// register scans the client slots, disconnect and stats scan the entries and then the
// client slots, all other codes scan the entries only; the final result is loaded in
// S_FIN, which then returns to idle, and no new request is taken until then; unknown
// codes are taken in idle and give nothing
// reset empties both tables at once through their valid bits
// a listed or freed entry or the final result waits while the output register is full
module keyed_reservation_table_unit import krt_pkg::*; #(
  parameter int ENTRIES      = 16,
  parameter int CLIENT_SLOTS = 16,
  parameter int NAME_BITS    = 64,
  parameter int ID_BITS      = 64,
  parameter int VALUE_BITS   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [3:0]            opcode_i,
  input  logic [NAME_BITS-1:0]  entry_name_i,
  input  logic [ID_BITS-1:0]    client_key_i,
  input  logic [VALUE_BITS-1:0] new_value_i,
  input  logic [1:0]            list_filter_i,
  input  logic [4:0]            max_items_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            status_o,
  output logic [NAME_BITS-1:0]  item_name_o,
  output logic [VALUE_BITS-1:0] item_value_o,
  output logic                  item_reserved_o,
  output logic [ID_BITS-1:0]    item_owner_o,
  output logic [4:0]            item_count_o,
  output logic [4:0]            used_total_o,
  output logic [4:0]            reserved_total_o,
  output logic [4:0]            client_total_o,
  output logic                  last_o
);

  localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW  = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int NW  = $clog2(ENTRIES + 1);
  localparam int CNW = $clog2(CLIENT_SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_ENT, S_CLI, S_FIN} state_e;

  function automatic logic [4:0] sat5(input int unsigned v);
    return (v > 31) ? 5'd31 : 5'(v);
  endfunction

  // tables
  logic [ENTRIES-1:0]      used_q, res_q;
  logic [NAME_BITS-1:0]    name_q  [ENTRIES];
  logic [VALUE_BITS-1:0]   value_q [ENTRIES];
  logic [ID_BITS-1:0]      owner_q [ENTRIES];
  logic [CLIENT_SLOTS-1:0] cvalid_q;
  logic [ID_BITS-1:0]      cid_q   [CLIENT_SLOTS];

  // latched request
  logic [3:0]            op_q;
  logic [NAME_BITS-1:0]  rname_q;
  logic [ID_BITS-1:0]    rid_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic [1:0]            filt_q;
  logic [4:0]            maxn_q;

  // sequencer state and scan results
  state_e         state_q;
  logic [EW-1:0]  e_idx_q;
  logic [CW-1:0]  c_idx_q;
  logic           hit_found_q, hit_res_q, hit_ow_q, free_found_q;
  logic [EW-1:0]  hit_idx_q, free_idx_q;
  logic           dup_q, cfree_found_q;
  logic [CW-1:0]  cfree_idx_q;
  logic [NW-1:0]  n_q, ucnt_q, rcnt_q;
  logic [CNW-1:0] ccnt_q;

  // output register
  logic                  out_valid_q;
  logic [2:0]            o_status_q;
  logic [NAME_BITS-1:0]  o_name_q;
  logic [VALUE_BITS-1:0] o_value_q;
  logic                  o_res_q;
  logic [ID_BITS-1:0]    o_owner_q;
  logic [4:0]            o_count_q, o_used_q, o_resv_q, o_cli_q;
  logic                  o_last_q;

  hit_t hit;

  krt_cmp #(
    .NAME_BITS (NAME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_cmp (
    .key_name_i   (rname_q),
    .key_id_i     (rid_q),
    .slot_name_i  (name_q[e_idx_q]),
    .slot_owner_i (owner_q[e_idx_q]),
    .client_id_i  (cid_q[c_idx_q]),
    .hit_o        (hit)
  );

  logic accept, out_free;
  logic u, r, v, below_max, filt_ok;
  logic disc_hit, list_hit, emit_ent, step;
  logic ent_last, cli_last, lookup_op;
  logic fin_create, fin_alter, fin_reserve, fin_release, fin_register;

  // result to load
  logic                  load;
  logic [2:0]            l_status;
  logic [NAME_BITS-1:0]  l_name;
  logic [VALUE_BITS-1:0] l_value;
  logic                  l_res;
  logic [ID_BITS-1:0]    l_owner;
  logic [4:0]            l_count, l_used, l_resv, l_cli;
  logic                  l_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    u         = used_q[e_idx_q];
    r         = res_q[e_idx_q];
    v         = cvalid_q[c_idx_q];
    below_max = (32'(n_q) < 32'(maxn_q));
    ent_last  = (e_idx_q == EW'(ENTRIES - 1));
    cli_last  = (c_idx_q == CW'(CLIENT_SLOTS - 1));
    lookup_op = (op_q == OP_CREATE) || (op_q == OP_READ) || (op_q == OP_ALTER) ||
                (op_q == OP_RESERVE) || (op_q == OP_RELEASE);
    if (filt_q == FILT_FREE) begin
      filt_ok = !r;
    end else if (filt_q == FILT_RESERVED) begin
      filt_ok = r;
    end else begin
      filt_ok = 1'b1;
    end

    disc_hit = (state_q == S_ENT) && (op_q == OP_DISCONNECT) && u && r && hit.owner_hit;
    list_hit = (state_q == S_ENT) && (op_q == OP_LIST) && u && filt_ok && below_max;
    emit_ent = (disc_hit && below_max) || list_hit;
    step     = !emit_ent || out_free;

    fin_create   = 1'b0;
    fin_alter    = 1'b0;
    fin_reserve  = 1'b0;
    fin_release  = 1'b0;
    fin_register = 1'b0;

    load     = 1'b0;
    l_status = ST_OK;
    l_name   = '0;
    l_value  = '0;
    l_res    = 1'b0;
    l_owner  = '0;
    l_count  = '0;
    l_used   = '0;
    l_resv   = '0;
    l_cli    = '0;
    l_last   = 1'b0;

    if (state_q == S_ENT && emit_ent && out_free) begin
      // one result per listed entry, and per freed entry while the count is below max_items
      load   = 1'b1;
      l_name = name_q[e_idx_q];
      if (op_q == OP_LIST) begin
        l_value = value_q[e_idx_q];
        l_res   = r;
        l_owner = r ? owner_q[e_idx_q] : '0;
      end
    end else if (state_q == S_FIN && out_free) begin
      load   = 1'b1;
      l_last = 1'b1;
      case (op_q)
        OP_REGISTER: begin
          if (dup_q) begin
            l_status = ST_DUP_ID;
          end else if (!cfree_found_q) begin
            l_status = ST_FULL;
          end else begin
            fin_register = 1'b1;
          end
        end
        OP_DISCONNECT, OP_LIST: l_count = sat5(32'(n_q));
        OP_CREATE: begin
          if (hit_found_q) begin
            l_status = ST_EXISTS;
          end else if (!free_found_q) begin
            l_status = ST_FULL;
          end else begin
            fin_create = 1'b1;
          end
        end
        OP_READ: begin
          if (hit_found_q) begin
            l_value = value_q[hit_idx_q];
          end else begin
            l_status = ST_MISSING;
          end
        end
        OP_ALTER, OP_RESERVE: begin
          if (!hit_found_q) begin
            l_status = ST_MISSING;
          end else if (hit_res_q && !hit_ow_q) begin
            l_status = ST_BUSY;
          end else if (op_q == OP_ALTER) begin
            fin_alter = 1'b1;
          end else begin
            fin_reserve = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (!hit_found_q) begin
            l_status = ST_MISSING;
          end else if (!hit_res_q) begin
            l_status = ST_UNHELD;
          end else if (!hit_ow_q) begin
            l_status = ST_FOREIGN;
          end else begin
            fin_release = 1'b1;
          end
        end
        OP_STATS: begin
          l_used = sat5(32'(ucnt_q));
          l_resv = sat5(32'(rcnt_q));
          l_cli  = sat5(32'(ccnt_q));
        end
        default: load = 1'b0;
      endcase
    end
  end

  // control, valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      used_q        <= '0;
      res_q         <= '0;
      cvalid_q      <= '0;
      out_valid_q   <= 1'b0;
      e_idx_q       <= '0;
      c_idx_q       <= '0;
      hit_found_q   <= 1'b0;
      hit_res_q     <= 1'b0;
      hit_ow_q      <= 1'b0;
      hit_idx_q     <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      cfree_found_q <= 1'b0;
      cfree_idx_q   <= '0;
      dup_q         <= 1'b0;
      n_q           <= '0;
      ucnt_q        <= '0;
      rcnt_q        <= '0;
      ccnt_q        <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            e_idx_q       <= '0;
            c_idx_q       <= '0;
            hit_found_q   <= 1'b0;
            free_found_q  <= 1'b0;
            cfree_found_q <= 1'b0;
            dup_q         <= 1'b0;
            n_q           <= '0;
            ucnt_q        <= '0;
            rcnt_q        <= '0;
            ccnt_q        <= '0;
            if (opcode_i == OP_REGISTER) begin
              state_q <= S_CLI;
            end else if (opcode_i inside {[OP_DISCONNECT:OP_STATS]}) begin
              state_q <= S_ENT;
            end
          end
        end
        S_ENT: begin
          if (step) begin
            if (lookup_op) begin
              if (u && hit.name_hit && !hit_found_q) begin
                hit_found_q <= 1'b1;
                hit_idx_q   <= e_idx_q;
                hit_res_q   <= r;
                hit_ow_q    <= hit.owner_hit;
              end
              if (!u && !free_found_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= e_idx_q;
              end
            end
            if (disc_hit) begin
              res_q[e_idx_q] <= 1'b0;
              n_q            <= n_q + NW'(1);
            end
            if (list_hit) begin
              n_q <= n_q + NW'(1);
            end
            if (op_q == OP_STATS) begin
              ucnt_q <= ucnt_q + NW'(u);
              rcnt_q <= rcnt_q + NW'(u && r);
            end
            if (ent_last) begin
              if (op_q == OP_DISCONNECT || op_q == OP_STATS) begin
                state_q <= S_CLI;
              end else begin
                state_q <= S_FIN;
              end
            end else begin
              e_idx_q <= e_idx_q + EW'(1);
            end
          end
        end
        S_CLI: begin
          case (op_q)
            OP_REGISTER: begin
              if (!v && !cfree_found_q) begin
                cfree_found_q <= 1'b1;
                cfree_idx_q   <= c_idx_q;
              end
              if (v && hit.client_hit) begin
                dup_q <= 1'b1;
              end
            end
            OP_DISCONNECT: begin
              if (v && hit.client_hit) begin
                cvalid_q[c_idx_q] <= 1'b0;
              end
            end
            OP_STATS: ccnt_q <= ccnt_q + CNW'(v);
            default: ;
          endcase
          if (cli_last) begin
            state_q <= S_FIN;
          end else begin
            c_idx_q <= c_idx_q + CW'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
          if (fin_register) begin
            cvalid_q[cfree_idx_q] <= 1'b1;
          end
          if (fin_create) begin
            used_q[free_idx_q] <= 1'b1;
            res_q[free_idx_q]  <= 1'b0;
          end
          if (fin_reserve) begin
            res_q[hit_idx_q] <= 1'b1;
          end
          if (fin_release) begin
            res_q[hit_idx_q] <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload: request latch, table words and result fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      rname_q <= entry_name_i;
      rid_q   <= client_key_i;
      rval_q  <= new_value_i;
      filt_q  <= list_filter_i;
      maxn_q  <= max_items_i;
    end
    if (fin_register) begin
      cid_q[cfree_idx_q] <= rid_q;
    end
    if (fin_create) begin
      name_q[free_idx_q]  <= rname_q;
      value_q[free_idx_q] <= rval_q;
    end
    if (fin_alter) begin
      value_q[hit_idx_q] <= rval_q;
    end
    if (fin_reserve) begin
      owner_q[hit_idx_q] <= rid_q;
    end
    if (load) begin
      o_status_q <= l_status;
      o_name_q   <= l_name;
      o_value_q  <= l_value;
      o_res_q    <= l_res;
      o_owner_q  <= l_owner;
      o_count_q  <= l_count;
      o_used_q   <= l_used;
      o_resv_q   <= l_resv;
      o_cli_q    <= l_cli;
      o_last_q   <= l_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = o_status_q;
  assign item_name_o      = o_name_q;
  assign item_value_o     = o_value_q;
  assign item_reserved_o  = o_res_q;
  assign item_owner_o     = o_owner_q;
  assign item_count_o     = o_count_q;
  assign used_total_o     = o_used_q;
  assign reserved_total_o = o_resv_q;
  assign client_total_o   = o_cli_q;
  assign last_o           = o_last_q;

endmodule

@@ design/krt_cmp.sv @@
module krt_cmp import krt_pkg::*; #(
  parameter int NAME_BITS = 64,
  parameter int ID_BITS   = 64
) (
  input  logic [NAME_BITS-1:0] key_name_i,
  input  logic [ID_BITS-1:0]   key_id_i,
  input  logic [NAME_BITS-1:0] slot_name_i,
  input  logic [ID_BITS-1:0]   slot_owner_i,
  input  logic [ID_BITS-1:0]   client_id_i,
  output hit_t                 hit_o
);

  // one compare bank shared by every scan step
  assign hit_o.name_hit   = (key_name_i == slot_name_i);
  assign hit_o.owner_hit  = (key_id_i == slot_owner_i);
  assign hit_o.client_hit = (key_id_i == client_id_i);

endmodule
